>>> rtl/sgfr_pkg.sv
// ----------------------------------------------------------------------------
// sgfr_pkg
// Types, constants and register codes shared by the shape gradient fill
// raster pipeline.
// ----------------------------------------------------------------------------
package sgfr_pkg;

  localparam int MAX_DIM = 2048;

  localparam int ROW_W   = 11;
  localparam int COL_W   = 11;
  localparam int PIX_W   = 24;
  localparam int CH_W    = 8;
  localparam int N_CH    = 3;
  localparam int H_W     = 12;
  localparam int EXT_W   = 12;
  localparam int MODE_W  = 3;
  localparam int CIDX_W  = 3;
  localparam int CDATA_W = 24;

  // Gradient numerator |end - start| * row, one quotient bit per divider stage
  localparam int NUM_W   = CH_W + ROW_W;

  // Signed coordinate difference and its square
  localparam int DIFF_W  = COL_W + 1;
  localparam int SQ_W    = 2 * COL_W;
  localparam int R2_W    = 2 * EXT_W;

  // Fill modes
  localparam logic [MODE_W-1:0] MODE_SOLID_BG   = 3'd0;
  localparam logic [MODE_W-1:0] MODE_GRAD_BG    = 3'd1;
  localparam logic [MODE_W-1:0] MODE_SOLID_DISC = 3'd2;
  localparam logic [MODE_W-1:0] MODE_GRAD_DISC  = 3'd3;
  localparam logic [MODE_W-1:0] MODE_SOLID_RECT = 3'd4;
  localparam logic [MODE_W-1:0] MODE_GRAD_RECT  = 3'd5;

  // Configuration register indexes
  localparam logic [CIDX_W-1:0] REG_MODE         = 3'd0;
  localparam logic [CIDX_W-1:0] REG_COLOR_START  = 3'd1;
  localparam logic [CIDX_W-1:0] REG_COLOR_END    = 3'd2;
  localparam logic [CIDX_W-1:0] REG_IMAGE_HEIGHT = 3'd3;
  localparam logic [CIDX_W-1:0] REG_ANCHOR_X     = 3'd4;
  localparam logic [CIDX_W-1:0] REG_ANCHOR_Y     = 3'd5;
  localparam logic [CIDX_W-1:0] REG_EXTENT_X     = 3'd6;
  localparam logic [CIDX_W-1:0] REG_EXTENT_Y     = 3'd7;

  typedef struct packed {
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
    logic [PIX_W-1:0] pixel_in;
  } sgfr_in_t;

  typedef struct packed {
    logic [PIX_W-1:0] pixel_out;
    logic             covered;
  } sgfr_out_t;

  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic [PIX_W-1:0]  color_start;
    logic [PIX_W-1:0]  color_end;
    logic [H_W-1:0]    image_height;
    logic [COL_W-1:0]  anchor_x;
    logic [ROW_W-1:0]  anchor_y;
    logic [EXT_W-1:0]  extent_x;
    logic [EXT_W-1:0]  extent_y;
  } sgfr_cfg_t;

  // Item moving through the divider: remainder and numerator/quotient per lane
  typedef struct packed {
    logic                       hit;
    logic [PIX_W-1:0]           pixel;
    logic [N_CH-1:0]            neg;
    logic [N_CH-1:0][H_W-1:0]   rem;
    logic [N_CH-1:0][NUM_W-1:0] num;
  } sgfr_div_t;

  function automatic logic is_gradient(logic [MODE_W-1:0] m);
    return (m == MODE_GRAD_BG) || (m == MODE_GRAD_DISC) || (m == MODE_GRAD_RECT);
  endfunction

endpackage

>>> rtl/sgfr_cfg_regs.sv
// ----------------------------------------------------------------------------
// sgfr_cfg_regs
// Configuration register file, written one register per transaction.
// ----------------------------------------------------------------------------
module sgfr_cfg_regs
  import sgfr_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [CIDX_W-1:0]  cfg_index,
  input  logic [CDATA_W-1:0] cfg_data,
  output sgfr_cfg_t          cfg
);

  sgfr_cfg_t cfg_r;
  sgfr_cfg_t cfg_nxt;

  assign cfg_ready = 1'b1;
  assign cfg       = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      case (cfg_index)
        REG_MODE:         cfg_nxt.mode         = cfg_data[MODE_W-1:0];
        REG_COLOR_START:  cfg_nxt.color_start  = cfg_data[PIX_W-1:0];
        REG_COLOR_END:    cfg_nxt.color_end    = cfg_data[PIX_W-1:0];
        REG_IMAGE_HEIGHT: cfg_nxt.image_height = cfg_data[H_W-1:0];
        REG_ANCHOR_X:     cfg_nxt.anchor_x     = cfg_data[COL_W-1:0];
        REG_ANCHOR_Y:     cfg_nxt.anchor_y     = cfg_data[ROW_W-1:0];
        REG_EXTENT_X:     cfg_nxt.extent_x     = cfg_data[EXT_W-1:0];
        REG_EXTENT_Y:     cfg_nxt.extent_y     = cfg_data[EXT_W-1:0];
        default:          cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      // all fields zero except a one-row image height
      cfg_r <= {MODE_W'(0), PIX_W'(0), PIX_W'(0), H_W'(1),
                COL_W'(0), ROW_W'(0), EXT_W'(0), EXT_W'(0)};
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

>>> rtl/sgfr_front.sv
// ----------------------------------------------------------------------------
// sgfr_front
// Coverage test and gradient numerator: clip and shape compares, squares and
// products, then the disc compare. Three register stages.
// ----------------------------------------------------------------------------
module sgfr_front
  import sgfr_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      en,
  input  logic      in_valid,
  input  sgfr_in_t  in_data,
  input  sgfr_cfg_t cfg,
  output logic      out_valid,
  output sgfr_div_t out_item
);

  // stage 1
  logic                          s1_valid_r;
  logic [ROW_W-1:0]              s1_row_r;
  logic [PIX_W-1:0]              s1_pixel_r;
  logic                          s1_fixed_hit_r;
  logic                          s1_disc_sel_r;
  logic signed [DIFF_W-1:0]      s1_dx_r;
  logic signed [DIFF_W-1:0]      s1_dy_r;
  logic [N_CH-1:0][CH_W-1:0]     s1_dmag_r;
  logic [N_CH-1:0]               s1_neg_r;

  // stage 2
  logic                          s2_valid_r;
  logic [PIX_W-1:0]              s2_pixel_r;
  logic                          s2_fixed_hit_r;
  logic                          s2_disc_sel_r;
  logic [SQ_W-1:0]               s2_dx2_r;
  logic [SQ_W-1:0]               s2_dy2_r;
  logic [R2_W-1:0]               s2_r2_r;
  logic [N_CH-1:0][NUM_W-1:0]    s2_prod_r;
  logic [N_CH-1:0]               s2_neg_r;

  // stage 3
  logic                          s3_valid_r;
  sgfr_div_t                     s3_item_r;

  // stage 1 combinational
  logic                          in_image;
  logic                          is_bg;
  logic                          is_disc;
  logic                          is_rect;
  logic                          rect_hit;
  logic [EXT_W:0]                ylim;
  logic [EXT_W:0]                xlim;
  logic [N_CH-1:0][CH_W-1:0]     dmag_nxt;
  logic [N_CH-1:0]               neg_nxt;

  // stage 2 / 3 combinational
  logic signed [2*DIFF_W-1:0]    dx_sq;
  logic signed [2*DIFF_W-1:0]    dy_sq;
  logic [SQ_W:0]                 dist2;
  sgfr_div_t                     s3_item_nxt;

  assign in_image = ({1'b0, in_data.row} < cfg.image_height) &&
                    ({1'b0, in_data.col} < (COL_W + 1)'(MAX_DIM));
  assign is_bg   = (cfg.mode == MODE_SOLID_BG)   || (cfg.mode == MODE_GRAD_BG);
  assign is_disc = (cfg.mode == MODE_SOLID_DISC) || (cfg.mode == MODE_GRAD_DISC);
  assign is_rect = (cfg.mode == MODE_SOLID_RECT) || (cfg.mode == MODE_GRAD_RECT);

  // image bottom and right edges are already covered by the in-image test
  assign ylim     = {2'b0, cfg.anchor_y} + {1'b0, cfg.extent_y};
  assign xlim     = {2'b0, cfg.anchor_x} + {1'b0, cfg.extent_x};
  assign rect_hit = (in_data.row >= cfg.anchor_y) && ({2'b0, in_data.row} < ylim) &&
                    (in_data.col >= cfg.anchor_x) && ({2'b0, in_data.col} < xlim);

  always_comb begin
    for (int ch = 0; ch < N_CH; ch++) begin
      neg_nxt[ch]  = cfg.color_end[ch*CH_W +: CH_W] < cfg.color_start[ch*CH_W +: CH_W];
      dmag_nxt[ch] = neg_nxt[ch] ?
                     cfg.color_start[ch*CH_W +: CH_W] - cfg.color_end[ch*CH_W +: CH_W] :
                     cfg.color_end[ch*CH_W +: CH_W] - cfg.color_start[ch*CH_W +: CH_W];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
      s3_valid_r <= 1'b0;
    end else if (en) begin
      s1_valid_r <= in_valid;
      s2_valid_r <= s1_valid_r;
      s3_valid_r <= s2_valid_r;
    end
  end

  assign dx_sq = s1_dx_r * s1_dx_r;
  assign dy_sq = s1_dy_r * s1_dy_r;

  assign dist2 = {1'b0, s2_dx2_r} + {1'b0, s2_dy2_r};

  always_comb begin
    s3_item_nxt       = '0;
    s3_item_nxt.hit   = s2_fixed_hit_r || (s2_disc_sel_r && ({1'b0, dist2} <= s2_r2_r));
    s3_item_nxt.pixel = s2_pixel_r;
    s3_item_nxt.neg   = s2_neg_r;
    s3_item_nxt.num   = s2_prod_r;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_row_r       <= in_data.row;
      s1_pixel_r     <= in_data.pixel_in;
      s1_fixed_hit_r <= in_image && (is_bg || (is_rect && rect_hit));
      s1_disc_sel_r  <= in_image && is_disc;
      s1_dx_r        <= $signed({1'b0, in_data.col}) - $signed({1'b0, cfg.anchor_x});
      s1_dy_r        <= $signed({1'b0, in_data.row}) - $signed({1'b0, cfg.anchor_y});
      s1_dmag_r      <= dmag_nxt;
      s1_neg_r       <= neg_nxt;

      s2_pixel_r     <= s1_pixel_r;
      s2_fixed_hit_r <= s1_fixed_hit_r;
      s2_disc_sel_r  <= s1_disc_sel_r;
      s2_dx2_r       <= dx_sq[SQ_W-1:0];
      s2_dy2_r       <= dy_sq[SQ_W-1:0];
      s2_r2_r        <= cfg.extent_x * cfg.extent_x;
      for (int ch = 0; ch < N_CH; ch++) begin
        s2_prod_r[ch] <= s1_dmag_r[ch] * s1_row_r;
      end
      s2_neg_r       <= s1_neg_r;

      s3_item_r      <= s3_item_nxt;
    end
  end

  assign out_valid = s3_valid_r;
  assign out_item  = s3_item_r;

endmodule

>>> rtl/sgfr_divider.sv
// ----------------------------------------------------------------------------
// sgfr_divider
// Pipelined restoring divider, three lanes, one quotient bit per stage.
// Numerator shifts out the top while quotient bits shift in at the bottom.
// ----------------------------------------------------------------------------
module sgfr_divider
  import sgfr_pkg::*;
(
  input  logic           clk,
  input  logic           rst_n,
  input  logic           en,
  input  logic [H_W-1:0] divisor,
  input  logic           in_valid,
  input  sgfr_div_t      in_item,
  output logic           out_valid,
  output sgfr_div_t      out_item
);

  function automatic sgfr_div_t div_step(sgfr_div_t a, logic [H_W-1:0] d);
    sgfr_div_t  b;
    logic [H_W:0] t;
    b = a;
    for (int ch = 0; ch < N_CH; ch++) begin
      t = {a.rem[ch], a.num[ch][NUM_W-1]};
      if (t >= {1'b0, d}) begin
        b.rem[ch] = H_W'(t - {1'b0, d});
        b.num[ch] = {a.num[ch][NUM_W-2:0], 1'b1};
      end else begin
        b.rem[ch] = t[H_W-1:0];
        b.num[ch] = {a.num[ch][NUM_W-2:0], 1'b0};
      end
    end
    return b;
  endfunction

  logic      stg_valid_r [NUM_W];
  sgfr_div_t stg_item_r  [NUM_W];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < NUM_W; k++) begin
        stg_valid_r[k] <= 1'b0;
      end
    end else if (en) begin
      stg_valid_r[0] <= in_valid;
      for (int k = 1; k < NUM_W; k++) begin
        stg_valid_r[k] <= stg_valid_r[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      stg_item_r[0] <= div_step(in_item, divisor);
      for (int k = 1; k < NUM_W; k++) begin
        stg_item_r[k] <= div_step(stg_item_r[k-1], divisor);
      end
    end
  end

  assign out_valid = stg_valid_r[NUM_W-1];
  assign out_item  = stg_item_r[NUM_W-1];

endmodule

>>> rtl/sgfr_out.sv
// ----------------------------------------------------------------------------
// sgfr_out
// Gradient assembly and colour select, output register and skid register.
// ----------------------------------------------------------------------------
module sgfr_out
  import sgfr_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  sgfr_cfg_t cfg,
  input  logic      pipe_valid,
  input  sgfr_div_t pipe_item,
  output logic      en,
  output logic      out_valid,
  input  logic      out_stall,
  output sgfr_out_t out_data
);

  localparam int SUM_W = NUM_W + 2;

  logic              out_valid_r;
  logic              out_valid_nxt;
  logic              skid_valid_r;
  logic              skid_valid_nxt;
  sgfr_out_t         out_r;
  sgfr_out_t         skid_r;
  sgfr_out_t         fin;
  logic [PIX_W-1:0]  grad;
  logic [SUM_W-1:0]  sv;
  logic [SUM_W-1:0]  qv;
  logic [SUM_W-1:0]  v;
  logic              leave;
  logic              out_free;

  // hold the whole pipeline while the skid register is occupied
  assign en       = !skid_valid_r;
  assign leave    = pipe_valid && en;
  assign out_free = !out_valid_r || !out_stall;

  always_comb begin
    grad = '0;
    sv   = '0;
    qv   = '0;
    v    = '0;
    for (int ch = 0; ch < N_CH; ch++) begin
      sv = SUM_W'(cfg.color_start[ch*CH_W +: CH_W]);
      qv = SUM_W'(pipe_item.num[ch]);
      v  = pipe_item.neg[ch] ? sv - qv : sv + qv;
      if (v[SUM_W-1]) begin
        grad[ch*CH_W +: CH_W] = '0;
      end else if (v > SUM_W'({CH_W{1'b1}})) begin
        grad[ch*CH_W +: CH_W] = '1;
      end else begin
        grad[ch*CH_W +: CH_W] = v[CH_W-1:0];
      end
    end
  end

  always_comb begin
    fin.covered = pipe_item.hit;
    if (!pipe_item.hit) begin
      fin.pixel_out = pipe_item.pixel;
    end else if (is_gradient(cfg.mode)) begin
      fin.pixel_out = grad;
    end else begin
      fin.pixel_out = cfg.color_start;
    end
  end

  always_comb begin
    out_valid_nxt  = out_valid_r;
    skid_valid_nxt = skid_valid_r;
    if (out_free) begin
      out_valid_nxt  = skid_valid_r || leave;
      skid_valid_nxt = 1'b0;
    end else if (leave) begin
      skid_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      out_r <= skid_valid_r ? skid_r : fin;
    end else if (leave) begin
      skid_r <= fin;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  a_skid_needs_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid register holds a transaction while the output is empty");

  a_blocked_to_skid: assert property (@(posedge clk) disable iff (!rst_n)
    (leave && out_valid_r && out_stall) |=> skid_valid_r)
    else $error("transaction leaving the pipeline was dropped");

  a_unused_mode: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_r.covered) |->
      (cfg.mode <= MODE_GRAD_RECT))
    else $error("pixel covered under an unused mode");

  a_solid_color: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_r.covered && !is_gradient(cfg.mode)) |->
      (out_r.pixel_out == cfg.color_start))
    else $error("solid fill does not match start color");

endmodule

>>> rtl/shape_gradient_fill_raster_top.sv
// ----------------------------------------------------------------------------
// shape_gradient_fill_raster_top
// Repaints streamed framebuffer pixels with a solid or vertical gradient fill
// over the whole image, a disc or a clipped rectangle.
// ----------------------------------------------------------------------------
//
//   channel  direction  handshake            payload
//   in       input      in_valid / in_stall   sgfr_in_t  (row, col, pixel_in)
//   out      output     out_valid / out_stall sgfr_out_t (pixel_out, covered)
//   cfg      input      cfg_valid / cfg_ready cfg_index, cfg_data
//
// One pixel per cycle while the output is not stalled; the path is three coverage
// and product stages, 19 divider stages (one quotient bit each) and the output
// register. Synchronous active-low reset clears all valid bits and loads the
// register reset values. A stalled output fills the skid register, then the
// whole pipeline and the input hold until the output transaction completes.
//
module shape_gradient_fill_raster_top
  import sgfr_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  sgfr_in_t           in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output sgfr_out_t          out_data,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [CIDX_W-1:0]  cfg_index,
  input  logic [CDATA_W-1:0] cfg_data
);

  sgfr_cfg_t cfg;
  logic      en;
  logic      front_valid;
  sgfr_div_t front_item;
  logic      div_valid;
  sgfr_div_t div_item;

  assign in_stall = !en;

  sgfr_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  sgfr_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (in_valid),
    .in_data   (in_data),
    .cfg       (cfg),
    .out_valid (front_valid),
    .out_item  (front_item)
  );

  sgfr_divider u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .divisor   (cfg.image_height),
    .in_valid  (front_valid),
    .in_item   (front_item),
    .out_valid (div_valid),
    .out_item  (div_item)
  );

  sgfr_out u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg),
    .pipe_valid (div_valid),
    .pipe_item  (div_item),
    .en         (en),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data)
  );

endmodule

>>> dv/sgfr_fill_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sgfr_fill_checker
// Watches the pixel, result and register channels of the shape fill raster
// block, keeps its own copy of the registers, predicts the repainted pixel
// and coverage flag for every accepted pixel and compares them in order.
// ----------------------------------------------------------------------------
module sgfr_fill_checker
  import sgfr_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_stall,
  input  sgfr_in_t           in_data,
  input  logic               out_valid,
  input  logic               out_stall,
  input  sgfr_out_t          out_data,
  input  logic               cfg_valid,
  input  logic               cfg_ready,
  input  logic [CIDX_W-1:0]  cfg_index,
  input  logic [CDATA_W-1:0] cfg_data,
  output int                 mismatches,
  output int                 pending,
  output int                 pixels_checked,
  output int                 pixels_covered
);

  sgfr_cfg_t fill_regs;
  sgfr_out_t expected_fills[$];
  sgfr_out_t want;

  // One color channel of the vertical ramp; division truncates toward zero
  function automatic logic [CH_W-1:0] ramp_channel(logic [CH_W-1:0] s, logic [CH_W-1:0] e,
                                                   logic [ROW_W-1:0] row, logic [H_W-1:0] h);
    longint d;
    longint v;
    d = longint'(e) - longint'(s);
    v = longint'(s) + (d * longint'(row)) / longint'(h);
    if (v < 0) v = 0;
    if (v > 255) v = 255;
    return CH_W'(v);
  endfunction

  function automatic sgfr_out_t predict_fill(sgfr_cfg_t c, sgfr_in_t px);
    sgfr_out_t res;
    logic      hit;
    longint    dx;
    longint    dy;
    longint    r;
    longint    ylim;
    longint    xlim;
    hit = 1'b0;
    if (px.row < c.image_height && int'(px.col) < MAX_DIM) begin
      case (c.mode)
        MODE_SOLID_BG, MODE_GRAD_BG: begin
          hit = 1'b1;
        end
        MODE_SOLID_DISC, MODE_GRAD_DISC: begin
          dx  = longint'(px.col) - longint'(c.anchor_x);
          dy  = longint'(px.row) - longint'(c.anchor_y);
          r   = longint'(c.extent_x);
          hit = (dx * dx + dy * dy) <= r * r;
        end
        MODE_SOLID_RECT, MODE_GRAD_RECT: begin
          ylim = longint'(c.anchor_y) + longint'(c.extent_y);
          xlim = longint'(c.anchor_x) + longint'(c.extent_x);
          if (ylim > longint'(c.image_height)) ylim = longint'(c.image_height);
          if (xlim > MAX_DIM) xlim = MAX_DIM;
          hit = px.row >= c.anchor_y && longint'(px.row) < ylim &&
                px.col >= c.anchor_x && longint'(px.col) < xlim;
        end
        default: begin
          hit = 1'b0;
        end
      endcase
    end
    res.covered   = hit;
    res.pixel_out = px.pixel_in;
    if (hit) begin
      if (c.mode == MODE_GRAD_BG || c.mode == MODE_GRAD_DISC || c.mode == MODE_GRAD_RECT) begin
        res.pixel_out[23:16] = ramp_channel(c.color_start[23:16], c.color_end[23:16],
                                            px.row, c.image_height);
        res.pixel_out[15:8]  = ramp_channel(c.color_start[15:8], c.color_end[15:8],
                                            px.row, c.image_height);
        res.pixel_out[7:0]   = ramp_channel(c.color_start[7:0], c.color_end[7:0],
                                            px.row, c.image_height);
      end else begin
        res.pixel_out = c.color_start;
      end
    end
    return res;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      fill_regs              = '0;
      fill_regs.image_height = H_W'(1);
      mismatches             = 0;
      pixels_checked         = 0;
      pixels_covered         = 0;
      expected_fills.delete();
    end else begin
      if (out_valid && !out_stall) begin
        pixels_checked++;
        if (out_data.covered) pixels_covered++;
        if (expected_fills.size() == 0) begin
          mismatches++;
          $display("%0t: unexpected result, expected none, actual pixel %06h covered %0b",
                   $time, out_data.pixel_out, out_data.covered);
        end else begin
          want = expected_fills.pop_front();
          if (out_data.pixel_out !== want.pixel_out) begin
            mismatches++;
            $display("%0t: pixel_out expected %06h actual %06h",
                     $time, want.pixel_out, out_data.pixel_out);
          end
          if (out_data.covered !== want.covered) begin
            mismatches++;
            $display("%0t: covered expected %0b actual %0b",
                     $time, want.covered, out_data.covered);
          end
        end
      end
      if (in_valid && !in_stall) expected_fills.push_back(predict_fill(fill_regs, in_data));
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_MODE:         fill_regs.mode         = cfg_data[MODE_W-1:0];
          REG_COLOR_START:  fill_regs.color_start  = cfg_data[PIX_W-1:0];
          REG_COLOR_END:    fill_regs.color_end    = cfg_data[PIX_W-1:0];
          REG_IMAGE_HEIGHT: fill_regs.image_height = cfg_data[H_W-1:0];
          REG_ANCHOR_X:     fill_regs.anchor_x     = cfg_data[COL_W-1:0];
          REG_ANCHOR_Y:     fill_regs.anchor_y     = cfg_data[ROW_W-1:0];
          REG_EXTENT_X:     fill_regs.extent_x     = cfg_data[EXT_W-1:0];
          REG_EXTENT_Y:     fill_regs.extent_y     = cfg_data[EXT_W-1:0];
          default: ;
        endcase
      end
    end
    pending = expected_fills.size();
  end

endmodule

>>> dv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives the shape fill raster block with directed corner pixels and then
// random pixel streams under a series of register settings, with random
// sender gaps and receiver stalls; the checker predicts and compares.
// ----------------------------------------------------------------------------
module testbench;
  import sgfr_pkg::*;

  localparam int CYCLE_LIMIT      = 400000;
  localparam int RANDOM_PHASES    = 12;
  localparam int PIXELS_PER_PHASE = 85;
  localparam int DRAIN_CYCLES     = 40;

  // Modes with no shape assigned
  localparam logic [MODE_W-1:0] MODE_UNUSED_6 = 3'd6;
  localparam logic [MODE_W-1:0] MODE_UNUSED_7 = 3'd7;

  logic               clk;
  logic               rst_n     = 1'b0;
  logic               in_valid  = 1'b0;
  logic               in_stall;
  sgfr_in_t           in_data   = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  sgfr_out_t          out_data;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [CIDX_W-1:0]  cfg_index = REG_MODE;
  logic [CDATA_W-1:0] cfg_data  = '0;

  int send_idle_pct    = 0;
  int recv_stall_pct   = 0;
  int cycles           = 0;
  int settings_applied = 0;
  int mismatches;
  int pending;
  int pixels_checked;
  int pixels_covered;

  shape_gradient_fill_raster_top DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  sgfr_fill_checker fill_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_data        (in_data),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_data       (out_data),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .mismatches     (mismatches),
    .pending        (pending),
    .pixels_checked (pixels_checked),
    .pixels_covered (pixels_covered)
  );

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  always @(posedge clk) begin
    out_stall <= rst_n && ($urandom_range(99) < recv_stall_pct);
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("%0t: timeout after %0d cycles, %0d pixels outstanding", $time, cycles, pending);
      $display("FAILED: results differ");
      $finish;
    end
  end

  function automatic sgfr_cfg_t make_setting(logic [MODE_W-1:0] m, logic [PIX_W-1:0] cs,
                                             logic [PIX_W-1:0] ce, int h, int ax, int ay,
                                             int ex, int ey);
    sgfr_cfg_t s;
    s.mode         = m;
    s.color_start  = cs;
    s.color_end    = ce;
    s.image_height = H_W'(h);
    s.anchor_x     = COL_W'(ax);
    s.anchor_y     = ROW_W'(ay);
    s.extent_x     = EXT_W'(ex);
    s.extent_y     = EXT_W'(ey);
    return s;
  endfunction

  function automatic logic [PIX_W-1:0] pick_color();
    case ($urandom_range(5))
      0:       return '0;
      1:       return '1;
      default: return PIX_W'($urandom);
    endcase
  endfunction

  function automatic int pick_anchor();
    case ($urandom_range(3))
      0:       return 0;
      1:       return 2047;
      default: return $urandom_range(2047);
    endcase
  endfunction

  function automatic int pick_extent();
    case ($urandom_range(5))
      0:       return 0;
      1:       return 2048;
      2:       return 4095;
      3, 4:    return $urandom_range(64);
      default: return $urandom_range(2048);
    endcase
  endfunction

  function automatic sgfr_cfg_t random_setting();
    sgfr_cfg_t s;
    int        h;
    case ($urandom_range(6))
      0:       s.mode = MODE_SOLID_BG;
      1:       s.mode = MODE_GRAD_BG;
      2:       s.mode = MODE_SOLID_DISC;
      3:       s.mode = MODE_GRAD_DISC;
      4:       s.mode = MODE_SOLID_RECT;
      5:       s.mode = MODE_GRAD_RECT;
      default: s.mode = $urandom_range(1) ? MODE_UNUSED_6 : MODE_UNUSED_7;
    endcase
    case ($urandom_range(5))
      0:       h = 1;
      1:       h = 2048;
      2:       h = $urandom_range(16, 1);
      3:       h = $urandom_range(4095, 2049);
      default: h = $urandom_range(2048, 1);
    endcase
    s.color_start  = pick_color();
    s.color_end    = pick_color();
    s.image_height = H_W'(h);
    s.anchor_x     = COL_W'(pick_anchor());
    s.anchor_y     = ROW_W'(pick_anchor());
    s.extent_x     = EXT_W'(pick_extent());
    s.extent_y     = EXT_W'(pick_extent());
    return s;
  endfunction

  // Coordinate within a small margin of a shape's span around its anchor
  function automatic logic [COL_W-1:0] near_coord(int c, int span);
    int lo;
    int hi;
    lo = c - span - 2;
    hi = c + span + 2;
    if (lo < 0) lo = 0;
    if (hi > 2047) hi = 2047;
    return COL_W'($urandom_range(hi, lo));
  endfunction

  function automatic sgfr_in_t random_pixel(sgfr_cfg_t s);
    sgfr_in_t px;
    int       lim;
    int       pick;
    logic     shaped;
    shaped = s.mode >= MODE_SOLID_DISC && s.mode <= MODE_GRAD_RECT;
    lim    = (s.image_height > 2048) ? 2048 : int'(s.image_height);
    pick   = $urandom_range(99);
    if (pick < 15 || lim == 0) begin
      px.row = ROW_W'($urandom_range(2047));
    end else if (shaped && pick < 60) begin
      px.row = near_coord(s.anchor_y, (s.mode <= MODE_GRAD_DISC) ? s.extent_x : s.extent_y);
    end else begin
      px.row = ROW_W'($urandom_range(lim - 1));
    end
    if (shaped && $urandom_range(99) < 60) px.col = near_coord(s.anchor_x, s.extent_x);
    else px.col = COL_W'($urandom_range(2047));
    px.pixel_in = PIX_W'($urandom);
    return px;
  endfunction

  task automatic send_pixel(input sgfr_in_t px);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(3, 1)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= px;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic send_at(input int row, input int col, input logic [PIX_W-1:0] pix);
    sgfr_in_t px;
    px.row      = ROW_W'(row);
    px.col      = COL_W'(col);
    px.pixel_in = pix;
    send_pixel(px);
  endtask

  task automatic wait_drained();
    do @(negedge clk); while (pending != 0);
    @(posedge clk);
  endtask

  task automatic put_reg(input logic [CIDX_W-1:0] idx, input logic [CDATA_W-1:0] val);
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
  endtask

  // Hold the pixel stream, let the pipeline empty, then load every register
  task automatic reprogram(input sgfr_cfg_t s);
    in_valid <= 1'b0;
    wait_drained();
    cfg_valid <= 1'b1;
    put_reg(REG_MODE,         CDATA_W'(s.mode));
    put_reg(REG_COLOR_START,  CDATA_W'(s.color_start));
    put_reg(REG_COLOR_END,    CDATA_W'(s.color_end));
    put_reg(REG_IMAGE_HEIGHT, CDATA_W'(s.image_height));
    put_reg(REG_ANCHOR_X,     CDATA_W'(s.anchor_x));
    put_reg(REG_ANCHOR_Y,     CDATA_W'(s.anchor_y));
    put_reg(REG_EXTENT_X,     CDATA_W'(s.extent_x));
    put_reg(REG_EXTENT_Y,     CDATA_W'(s.extent_y));
    cfg_valid <= 1'b0;
    settings_applied++;
  endtask

  initial begin : stimulus
    sgfr_cfg_t s;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Registers at reset: one row tall, solid black over the whole image
    send_at(0, 5, 24'hABCDEF);
    send_at(1, 0, 24'h123456);
    send_at(2047, 2047, 24'hFFFFFF);

    // Full-height ramp; green falls, so small rows must truncate toward zero
    reprogram(make_setting(MODE_GRAD_BG, 24'h00FF80, 24'hFF0080, 2048, 0, 0, 0, 0));
    send_at(0, 0, 24'h000000);
    send_at(1, 2047, 24'hFFFFFF);
    send_at(1024, 7, 24'h5A5A5A);
    send_at(2047, 1000, 24'hA5A5A5);

    // Disc edge: on-radius points are in, one column further is out
    reprogram(make_setting(MODE_GRAD_DISC, 24'hFFFFFF, 24'h000000, 2048, 1000, 1000, 100, 0));
    send_at(1000, 1000, 24'h010203);
    send_at(1000, 1100, 24'h040506);
    send_at(1000, 1101, 24'h070809);
    send_at(1080, 1060, 24'h0A0B0C);
    send_at(1080, 1061, 24'h0D0E0F);

    // Rectangle clipped by both the image height and the column limit
    reprogram(make_setting(MODE_SOLID_RECT, 24'hFFFFFF, 24'h000000, 2044, 2040, 2040, 2048,
                           2048));
    send_at(2043, 2047, 24'h000000);
    send_at(2044, 2047, 24'h111111);
    send_at(2041, 2039, 24'h222222);

    reprogram(make_setting(MODE_UNUSED_6, 24'hFFFFFF, 24'hFFFFFF, 2048, 0, 0, 4095, 4095));
    send_at(5, 5, 24'h333333);

    // Zero height: nothing is inside the image
    reprogram(make_setting(MODE_SOLID_BG, 24'h00FF00, 24'h000000, 0, 0, 0, 0, 0));
    send_at(0, 0, 24'h444444);

    // Zero radius covers the center alone
    reprogram(make_setting(MODE_SOLID_DISC, 24'h0000FF, 24'h000000, 4095, 0, 0, 0, 0));
    send_at(0, 0, 24'h555555);
    send_at(0, 1, 24'h666666);

    reprogram(make_setting(MODE_GRAD_RECT, 24'hFF00FF, 24'h00FF00, 16, 3, 2, 4, 5));
    send_at(2, 3, 24'h777777);
    send_at(6, 6, 24'h888888);
    send_at(7, 3, 24'h999999);
    send_at(2, 7, 24'hAAAAAA);

    reprogram(make_setting(MODE_UNUSED_7, 24'h123456, 24'h654321, 2048, 0, 0, 2048, 2048));
    send_at(100, 100, 24'hBBBBBB);

    for (int p = 0; p < RANDOM_PHASES; p++) begin
      s = random_setting();
      reprogram(s);
      send_idle_pct  = (p < 4) ? 26 : (p < 8) ? 85 : 0;
      recv_stall_pct = (p < 4) ? 85 : (p < 8) ? 26 : 0;
      for (int n = 0; n < PIXELS_PER_PHASE; n++) begin
        // Hold the stream mid-phase until the pipeline runs dry
        if (n == PIXELS_PER_PHASE / 2 && p % 3 == 1) begin
          in_valid <= 1'b0;
          wait_drained();
        end
        send_pixel(random_pixel(s));
      end
    end

    in_valid <= 1'b0;
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Run checked %0d pixels under %0d register settings, %0d of them painted.",
             pixels_checked, settings_applied, pixels_covered);
    $display("Shapes: full image, disc and clipped rectangle, solid and ramp fills.");
    if (mismatches == 0 && pending == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
